// ===== rtl/pbrq_pkg.sv =====
// Package: constants, request codes, sequencer states and memory entries for the run queue.
package pbrq_pkg;
	localparam int NumLevels = 32;
	localparam int MaxTasks  = 32;
	localparam int LvlW      = 5;
	localparam int TaskW     = 5;

	typedef enum logic [1:0] {
		ACT_ADD     = 2'd0,
		ACT_REQUEUE = 2'd1,
		ACT_REMOVE  = 2'd2,
		ACT_PICK    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_LINK_RD,
		ST_LINK_WR,
		ST_UNLINK_T,
		ST_UNLINK_L,
		ST_UNLINK_P,
		ST_UNLINK_N
	} sched_state_t;

	typedef struct packed {
		logic [TaskW-1:0] head;
		logic [TaskW-1:0] tail;
	} level_ent_t;

	typedef struct packed {
		logic [TaskW-1:0] nxt;
		logic [TaskW-1:0] prv;
		logic [LvlW-1:0]  lvl;
	} task_ent_t;
endpackage

// ===== rtl/priority_bitmap_run_queue.sv =====
// Top level: bitmap priority run queue with per-level linked FIFO lists.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: action,
//   task_id, priority_req, quantum_left. Output channel (out_valid/out_ready)
//   returns one result beat per request: chosen_task, found and status.
//   Head/tail pointers sit in a level memory and next/prev/level in a task
//   memory, both with a registered read port; the level bitmap and the
//   queued flags are registers. Requests run one at a time through a small
//   sequencer. Rejects, an empty pick and an add into an empty level are
//   answered from IDLE; a pick that finds a task passes PICK, an add into a
//   busy level LINK_RD and LINK_WR, removing a list's head or tail UNLINK_T
//   and UNLINK_L, removing a middle task also UNLINK_P and UNLINK_N, as the
//   memory reads and write-backs need. The next request is taken at the edge
//   that takes the result.
//   Reset clears the bitmap, the queued flags and the output valid; memory
//   entries are always written before they are read, so they need no clearing.
//   When the receiver stalls, the result holds and in_ready stays low.
module priority_bitmap_run_queue (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [4:0] task_id,
	input  logic [4:0] priority_req,
	input  logic [7:0] quantum_left,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] chosen_task,
	output logic       found,
	output logic       status
);
	pbrq_pkg::sched_state_t state_q, state_d;
	logic [pbrq_pkg::NumLevels-1:0] bitmap_q, bitmap_d;
	logic [pbrq_pkg::MaxTasks-1:0]  queued_q, queued_d;

	pbrq_pkg::level_ent_t level_mem [pbrq_pkg::NumLevels];
	pbrq_pkg::task_ent_t  task_mem  [pbrq_pkg::MaxTasks];
	pbrq_pkg::level_ent_t lvl_rd_q, lvl_wdata;
	pbrq_pkg::task_ent_t  task_rd_q, task_wdata;
	logic                       lvl_we, task_we;
	logic [pbrq_pkg::LvlW-1:0]  lvl_raddr, lvl_waddr;
	logic [pbrq_pkg::TaskW-1:0] task_raddr, task_waddr;

	logic [pbrq_pkg::TaskW-1:0] req_tid_q;
	logic [pbrq_pkg::LvlW-1:0]  req_lvl_q;
	logic                       req_head_q;
	logic [pbrq_pkg::TaskW-1:0] nb_q, un_next_q, un_prev_q;
	logic [pbrq_pkg::LvlW-1:0]  ulvl_q;

	pbrq_pkg::action_t          act_in;
	logic                       fire;
	logic                       pick_hit;
	logic [pbrq_pkg::LvlW-1:0]  pick_lvl;
	logic                       lvl_busy;
	logic                       un_is_head, un_is_tail;
	logic                       res_load;
	logic [pbrq_pkg::TaskW-1:0] res_chosen;
	logic                       res_found, res_status;

	assign act_in     = pbrq_pkg::action_t'(action);
	assign in_ready   = (state_q == pbrq_pkg::ST_IDLE) && (!out_valid || out_ready);
	assign fire       = in_valid && in_ready;
	assign lvl_busy   = bitmap_q[priority_req];
	assign un_is_head = lvl_rd_q.head == req_tid_q;
	assign un_is_tail = lvl_rd_q.tail == req_tid_q;

	// Find the highest non-empty level
	always_comb begin
		pick_hit = 1'b0;
		pick_lvl = '0;
		for (int l = 0; l < pbrq_pkg::NumLevels; l++) begin
			if (bitmap_q[l]) begin
				pick_hit = 1'b1;
				pick_lvl = pbrq_pkg::LvlW'(l);
			end
		end
	end

	// Next state of the request sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbrq_pkg::ST_IDLE: begin
				if (fire) begin
					case (act_in)
						pbrq_pkg::ACT_PICK: begin
							if (pick_hit) state_d = pbrq_pkg::ST_PICK;
						end
						pbrq_pkg::ACT_REMOVE: begin
							if (queued_q[task_id]) state_d = pbrq_pkg::ST_UNLINK_T;
						end
						default: begin
							if (!queued_q[task_id] && lvl_busy) state_d = pbrq_pkg::ST_LINK_RD;
						end
					endcase
				end
			end
			pbrq_pkg::ST_PICK:     state_d = pbrq_pkg::ST_IDLE;
			pbrq_pkg::ST_LINK_RD:  state_d = pbrq_pkg::ST_LINK_WR;
			pbrq_pkg::ST_LINK_WR:  state_d = pbrq_pkg::ST_IDLE;
			pbrq_pkg::ST_UNLINK_T: state_d = pbrq_pkg::ST_UNLINK_L;
			pbrq_pkg::ST_UNLINK_L: begin
				if (un_is_head || un_is_tail) state_d = pbrq_pkg::ST_IDLE;
				else state_d = pbrq_pkg::ST_UNLINK_P;
			end
			pbrq_pkg::ST_UNLINK_P: state_d = pbrq_pkg::ST_UNLINK_N;
			pbrq_pkg::ST_UNLINK_N: state_d = pbrq_pkg::ST_IDLE;
			default:               state_d = pbrq_pkg::ST_IDLE;
		endcase
	end

	// Memory accesses, flag updates and result for the current step
	always_comb begin
		lvl_raddr  = priority_req;
		task_raddr = task_id;
		lvl_we     = 1'b0;
		lvl_waddr  = '0;
		lvl_wdata  = '0;
		task_we    = 1'b0;
		task_waddr = '0;
		task_wdata = '0;
		bitmap_d   = bitmap_q;
		queued_d   = queued_q;
		res_load   = 1'b0;
		res_chosen = '0;
		res_found  = 1'b0;
		res_status = 1'b0;
		case (state_q)
			pbrq_pkg::ST_IDLE: begin
				if (act_in == pbrq_pkg::ACT_PICK) lvl_raddr = pick_lvl;
				if (fire) begin
					case (act_in)
						pbrq_pkg::ACT_PICK: begin
							if (!pick_hit) res_load = 1'b1;
						end
						pbrq_pkg::ACT_REMOVE: begin
							if (queued_q[task_id]) begin
								queued_d[task_id] = 1'b0;
							end else begin
								res_load   = 1'b1;
								res_status = 1'b1;
							end
						end
						default: begin
							if (queued_q[task_id]) begin
								res_load   = 1'b1;
								res_status = 1'b1;
							end else begin
								queued_d[task_id]      = 1'b1;
								bitmap_d[priority_req] = 1'b1;
								// Empty level: the task becomes head and tail at once
								if (!lvl_busy) begin
									lvl_we         = 1'b1;
									lvl_waddr      = priority_req;
									lvl_wdata.head = task_id;
									lvl_wdata.tail = task_id;
									task_we        = 1'b1;
									task_waddr     = task_id;
									task_wdata.lvl = priority_req;
									res_load       = 1'b1;
								end
							end
						end
					endcase
				end
			end
			pbrq_pkg::ST_PICK: begin
				res_load   = 1'b1;
				res_chosen = lvl_rd_q.head;
				res_found  = 1'b1;
			end
			// Busy level: move the end pointer, write the new entry, fetch the neighbor
			pbrq_pkg::ST_LINK_RD: begin
				task_raddr     = req_head_q ? lvl_rd_q.head : lvl_rd_q.tail;
				lvl_we         = 1'b1;
				lvl_waddr      = req_lvl_q;
				lvl_wdata      = lvl_rd_q;
				task_we        = 1'b1;
				task_waddr     = req_tid_q;
				task_wdata.lvl = req_lvl_q;
				if (req_head_q) begin
					lvl_wdata.head = req_tid_q;
					task_wdata.nxt = lvl_rd_q.head;
				end else begin
					lvl_wdata.tail = req_tid_q;
					task_wdata.prv = lvl_rd_q.tail;
				end
			end
			// Point the neighbor back at the new task
			pbrq_pkg::ST_LINK_WR: begin
				task_we    = 1'b1;
				task_waddr = nb_q;
				task_wdata = task_rd_q;
				if (req_head_q) task_wdata.prv = req_tid_q;
				else task_wdata.nxt = req_tid_q;
				res_load   = 1'b1;
			end
			pbrq_pkg::ST_UNLINK_T: begin
				lvl_raddr = task_rd_q.lvl;
			end
			// Drop the level bit, move an end pointer, or fetch the predecessor
			pbrq_pkg::ST_UNLINK_L: begin
				task_raddr = un_prev_q;
				if (un_is_head && un_is_tail) begin
					bitmap_d[ulvl_q] = 1'b0;
					res_load         = 1'b1;
				end else if (un_is_head) begin
					lvl_we         = 1'b1;
					lvl_waddr      = ulvl_q;
					lvl_wdata      = lvl_rd_q;
					lvl_wdata.head = un_next_q;
					res_load       = 1'b1;
				end else if (un_is_tail) begin
					lvl_we         = 1'b1;
					lvl_waddr      = ulvl_q;
					lvl_wdata      = lvl_rd_q;
					lvl_wdata.tail = un_prev_q;
					res_load       = 1'b1;
				end
			end
			pbrq_pkg::ST_UNLINK_P: begin
				task_raddr     = un_next_q;
				task_we        = 1'b1;
				task_waddr     = un_prev_q;
				task_wdata     = task_rd_q;
				task_wdata.nxt = un_next_q;
			end
			pbrq_pkg::ST_UNLINK_N: begin
				task_we        = 1'b1;
				task_waddr     = un_next_q;
				task_wdata     = task_rd_q;
				task_wdata.prv = un_prev_q;
				res_load       = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer state, flags and the request being worked on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pbrq_pkg::ST_IDLE;
			bitmap_q   <= '0;
			queued_q   <= '0;
			req_tid_q  <= '0;
			req_lvl_q  <= '0;
			req_head_q <= 1'b0;
			nb_q       <= '0;
			un_next_q  <= '0;
			un_prev_q  <= '0;
			ulvl_q     <= '0;
		end else begin
			state_q  <= state_d;
			bitmap_q <= bitmap_d;
			queued_q <= queued_d;
			if (fire) begin
				req_tid_q  <= task_id;
				req_lvl_q  <= priority_req;
				req_head_q <= (act_in == pbrq_pkg::ACT_REQUEUE) && (quantum_left != 8'd0);
			end
			if (state_q == pbrq_pkg::ST_LINK_RD) nb_q <= task_raddr;
			if (state_q == pbrq_pkg::ST_UNLINK_T) begin
				un_next_q <= task_rd_q.nxt;
				un_prev_q <= task_rd_q.prv;
				ulvl_q    <= task_rd_q.lvl;
			end
		end
	end

	// Result register: load on completion, hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			chosen_task <= '0;
			found       <= 1'b0;
			status      <= 1'b0;
		end else if (res_load) begin
			out_valid   <= 1'b1;
			chosen_task <= res_chosen;
			found       <= res_found;
			status      <= res_status;
		end else if (out_ready) begin
			out_valid   <= 1'b0;
		end
	end

	// Level memory: head and tail per level
	always_ff @(posedge clk) begin
		if (lvl_we) level_mem[lvl_waddr] <= lvl_wdata;
		lvl_rd_q <= level_mem[lvl_raddr];
	end

	// Task memory: next, prev and level per task
	always_ff @(posedge clk) begin
		if (task_we) task_mem[task_waddr] <= task_wdata;
		task_rd_q <= task_mem[task_raddr];
	end
endmodule
